>>> rtl/hgf_pkg.sv
// ----------------------------------------------------------------------------
// hgf_pkg
// Types and constants for the histogram free-gap finder: the result beat,
// configuration register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package hgf_pkg;

  // Field widths
  localparam int unsigned ThrW    = 24;
  localparam int unsigned NarrowW = 8;
  localparam int unsigned PosW    = 8;
  localparam int unsigned WidW    = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 24;

  // Default histogram size
  localparam int unsigned NumBinsDefault = 128;

  // Result queue depth (two results at most per bin)
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFreeThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgNarrowWidth   = 1'b1;

  // Configuration reset values
  localparam logic [ThrW-1:0]    FreeThresholdReset = '0;
  localparam logic [NarrowW-1:0] NarrowWidthReset   = 8'd16;

  // One result beat
  typedef struct packed {
    logic              found;
    logic              narrow;
    logic [PosW-1:0]   position_half_bins;
    logic [WidW-1:0]   width_bins;
    logic              last_segment;
  } result_t;

endpackage

>>> rtl/histogram_free_gap_finder.sv
// ----------------------------------------------------------------------------
// histogram_free_gap_finder
// Streams polar histogram bins, finds circular runs of free bins (valleys)
// and reports each as it closes; a run from bin 0 is joined across the wrap.
// ----------------------------------------------------------------------------
// Path: an accepted bin is held in the input register, then one pass of
// run logic writes its results into a 4-entry result queue.
// Throughput: one bin per cycle while the queue keeps room for two results.
// Reset: asynchronous, active low; clears run state, queue and config
// (threshold 0, narrow width 16).
module histogram_free_gap_finder #(
  parameter int unsigned NUM_BINS = hgf_pkg::NumBinsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         cfg_we_i,
  input  logic [hgf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hgf_pkg::CfgW-1:0]     cfg_data_i,
  // Bin input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [hgf_pkg::ThrW-1:0]     bin_value_i,
  input  logic                         last_bin_i,
  // Result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic                         narrow_o,
  output logic [hgf_pkg::PosW-1:0]     position_half_bins_o,
  output logic [hgf_pkg::WidW-1:0]     width_bins_o,
  output logic                         last_segment_o
);
  import hgf_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_BINS);
  localparam int unsigned W2   = IdxW + 2;
  localparam int unsigned CW   = (W2 > 9) ? W2 : 9;
  localparam int unsigned QAW  = $clog2(QueueDepth);
  localparam int unsigned QCW  = QAW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BINS - 1);
  localparam logic [QCW-1:0]  RoomMax = QCW'(QueueDepth - 2);

  // Build one valley result
  function automatic result_t valley(input logic [IdxW-1:0]    start,
                                     input logic [W2-1:0]      gap,
                                     input logic [IdxW:0]      n,
                                     input logic [NarrowW-1:0] nw);
    logic [W2-1:0] mid;
    logic [W2-1:0] twon;
    logic [CW-1:0] gap_c;
    logic [CW-1:0] nw_c;
    logic [CW-1:0] mid_c;
    logic [CW-1:0] st2_c;
    result_t       r;
    mid   = W2'({start, 1'b0}) + gap;
    twon  = W2'({n, 1'b0});
    if (mid >= twon) begin
      mid = mid - twon;
    end
    gap_c = CW'(gap);
    nw_c  = CW'(nw);
    mid_c = CW'(mid);
    st2_c = CW'({start, 1'b0});
    r.found        = 1'b1;
    r.last_segment = 1'b0;
    if (gap_c < nw_c) begin
      r.narrow             = 1'b1;
      r.position_half_bins = mid_c[PosW-1:0];
      r.width_bins         = WidW'(1);
    end else begin
      r.narrow             = 1'b0;
      r.position_half_bins = st2_c[PosW-1:0];
      r.width_bins         = gap_c[WidW-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [ThrW-1:0]    threshold_q;
  logic [NarrowW-1:0] narrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= FreeThresholdReset;
      narrow_q    <= NarrowWidthReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgFreeThreshold) begin
        threshold_q <= cfg_data_i[ThrW-1:0];
      end else if (cfg_index_i == CfgNarrowWidth) begin
        narrow_q <= cfg_data_i[NarrowW-1:0];
      end
    end
  end

  // Input register
  logic            stage_valid_q;
  logic [ThrW-1:0] stage_value_q;
  logic            stage_last_q;
  logic            advance;
  logic            in_fire;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = !stage_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_fire) begin
      stage_valid_q <= 1'b1;
    end else if (advance) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_value_q <= bin_value_i;
      stage_last_q  <= last_bin_i;
    end
  end

  // Run state
  logic [IdxW-1:0] bin_index_q;
  logic            run_open_q;
  logic [IdxW-1:0] run_start_q;
  logic [IdxW-1:0] first_end_q;
  logic            first_seen_q;
  logic            any_emitted_q;

  // Result queue
  result_t          queue_q [QueueDepth];
  logic [QAW-1:0]   wr_ptr_q;
  logic [QAW-1:0]   rd_ptr_q;
  logic [QCW-1:0]   count_q;
  logic             pop;

  assign advance = stage_valid_q && (count_q <= RoomMax);

  // Run update and result build for the bin in the input register
  logic            is_last;
  logic            is_free;
  logic            close_emit;
  logic            run_open_n;
  logic [IdxW-1:0] run_start_n;
  logic [IdxW-1:0] first_end_n;
  logic            first_seen_n;
  logic [IdxW:0]   n_bins;
  logic [W2-1:0]   end_gap;
  logic            has_b;
  result_t         res_a;
  result_t         res_b;

  always_comb begin
    is_last      = stage_last_q || (bin_index_q == LastIdx);
    is_free      = stage_value_q <= threshold_q;
    n_bins       = {1'b0, bin_index_q} + (IdxW+1)'(1);
    run_open_n   = run_open_q;
    run_start_n  = run_start_q;
    first_end_n  = first_end_q;
    first_seen_n = first_seen_q;
    close_emit   = 1'b0;

    // open or close the current run
    if (is_free) begin
      if (!run_open_q) begin
        run_open_n  = 1'b1;
        run_start_n = bin_index_q;
      end
    end else if (run_open_q) begin
      run_open_n = 1'b0;
      if (run_start_q == '0) begin
        first_seen_n = 1'b1;
        first_end_n  = bin_index_q;
      end else begin
        close_emit = 1'b1;
      end
    end

    res_a = valley(run_start_q, W2'(bin_index_q - run_start_q), n_bins, narrow_q);

    // wrap-around closing at the last bin
    end_gap = (first_seen_n ? W2'(first_end_n) : W2'(0)) + W2'(n_bins) - W2'(run_start_n);
    has_b   = 1'b0;
    res_b   = '0;
    if (is_last) begin
      priority if (run_open_n) begin
        has_b = 1'b1;
        res_b = valley(run_start_n, end_gap, n_bins, narrow_q);
      end else if (first_seen_n) begin
        has_b = 1'b1;
        res_b = valley('0, W2'(first_end_n), n_bins, narrow_q);
      end else begin
        // not-found beat only when no valley came out for this histogram
        has_b = !(any_emitted_q || close_emit);
      end
      if (has_b) begin
        res_b.last_segment = 1'b1;
      end else begin
        res_a.last_segment = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_index_q   <= '0;
      run_open_q    <= 1'b0;
      run_start_q   <= '0;
      first_end_q   <= '0;
      first_seen_q  <= 1'b0;
      any_emitted_q <= 1'b0;
    end else if (advance) begin
      if (is_last) begin
        bin_index_q   <= '0;
        run_open_q    <= 1'b0;
        run_start_q   <= '0;
        first_end_q   <= '0;
        first_seen_q  <= 1'b0;
        any_emitted_q <= 1'b0;
      end else begin
        bin_index_q   <= bin_index_q + IdxW'(1);
        run_open_q    <= run_open_n;
        run_start_q   <= run_start_n;
        first_end_q   <= first_end_n;
        first_seen_q  <= first_seen_n;
        any_emitted_q <= any_emitted_q || close_emit;
      end
    end
  end

  // Queue write: zero, one or two beats per bin
  logic            push_a;
  logic            push_b;
  logic [QCW-1:0]  push_cnt;

  assign push_a   = advance && close_emit;
  assign push_b   = advance && has_b;
  assign push_cnt = QCW'(push_a) + QCW'(push_b);
  assign pop      = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      queue_q[wr_ptr_q] <= res_a;
    end
    if (push_b) begin
      queue_q[push_a ? wr_ptr_q + QAW'(1) : wr_ptr_q] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QAW'(push_cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      count_q <= count_q + push_cnt - QCW'(pop);
    end
  end

  // Output beat
  result_t head;
  assign head                 = queue_q[rd_ptr_q];
  assign out_valid_o          = count_q != '0;
  assign found_o              = head.found;
  assign narrow_o             = head.narrow;
  assign position_half_bins_o = head.position_half_bins;
  assign width_bins_o         = head.width_bins;
  assign last_segment_o       = head.last_segment;

endmodule
